>>> hw/rtl/shfr_pkg.sv
// Shared types and constants for the sync-header CRC-16 frame receiver.
package shfr_pkg;

  localparam int FRAME_BYTES = 39;
  localparam int POS_W       = 6;

  localparam logic [7:0]  SYNC_FIRST  = 8'h41;
  localparam logic [7:0]  SYNC_SECOND = 8'h43;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_TOP     = 16'h8000;

  localparam logic [POS_W-1:0] END_POS = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] CHK_POS = POS_W'(FRAME_BYTES - 2);

  typedef enum logic [1:0] {
    PH_WAIT_A  = 2'd0,
    PH_WAIT_C  = 2'd1,
    PH_COLLECT = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_DROP    = 2'd0,
    ST_TAKEN   = 2'd1,
    ST_CRC_OK  = 2'd2,
    ST_CRC_BAD = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       abort;
  } item_t;

  typedef struct packed {
    status_t          status;
    logic [7:0]       frame_byte;
    logic [POS_W-1:0] position;
  } result_t;

endpackage

>>> hw/rtl/shfr_crc_byte.sv
// CRC-16/CCITT-FALSE update over one byte, eight bit steps unrolled.
module shfr_crc_byte (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);
  import shfr_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

>>> hw/rtl/shfr_frame_ctrl.sv
// Frame state machine: sync hunt, byte counting, CRC tracking and status.
module shfr_frame_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  shfr_pkg::item_t item,
  output shfr_pkg::result_t res
);
  import shfr_pkg::*;

  phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0] count_r, count_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       low_r, low_nxt;
  logic [15:0]      crc_seed, crc_fed;
  logic [7:0]       b;

  assign b = item.rx_byte;

  // a sync byte outside collection restarts the CRC from its initial value
  assign crc_seed = (phase_r != PH_COLLECT && b == SYNC_FIRST) ? CRC_INIT : crc_r;

  shfr_crc_byte u_crc (
    .crc_in  (crc_seed),
    .data    (b),
    .crc_out (crc_fed)
  );

  always_comb begin
    phase_nxt      = phase_r;
    count_nxt      = count_r;
    crc_nxt        = crc_r;
    low_nxt        = low_r;
    res.status     = ST_DROP;
    res.frame_byte = b;
    res.position   = '0;
    if (item.abort) begin
      phase_nxt = PH_WAIT_A;
      count_nxt = '0;
      crc_nxt   = CRC_INIT;
      low_nxt   = '0;
    end else begin
      unique case (phase_r)
        PH_WAIT_C: begin
          if (b == SYNC_SECOND) begin
            phase_nxt    = PH_COLLECT;
            count_nxt    = POS_W'(2);
            crc_nxt      = crc_fed;
            res.status   = ST_TAKEN;
            res.position = POS_W'(1);
          end else if (b == SYNC_FIRST) begin
            phase_nxt  = PH_WAIT_C;
            count_nxt  = POS_W'(1);
            crc_nxt    = crc_fed;
            low_nxt    = '0;
            res.status = ST_TAKEN;
          end else begin
            phase_nxt = PH_WAIT_A;
            count_nxt = '0;
            crc_nxt   = CRC_INIT;
            low_nxt   = '0;
          end
        end
        PH_COLLECT: begin
          res.position = count_r;
          if (count_r >= END_POS) begin
            // check field arrives low byte first
            res.status = ({b, low_r} == crc_r) ? ST_CRC_OK : ST_CRC_BAD;
            phase_nxt  = PH_WAIT_A;
            count_nxt  = '0;
            crc_nxt    = CRC_INIT;
            low_nxt    = '0;
          end else begin
            if (count_r < CHK_POS) begin
              crc_nxt = crc_fed;
            end else begin
              low_nxt = b;
            end
            count_nxt  = count_r + POS_W'(1);
            res.status = ST_TAKEN;
          end
        end
        default: begin
          // waiting for the first sync byte, also the unused phase code
          if (b == SYNC_FIRST) begin
            phase_nxt  = PH_WAIT_C;
            count_nxt  = POS_W'(1);
            crc_nxt    = crc_fed;
            low_nxt    = '0;
            res.status = ST_TAKEN;
          end else begin
            phase_nxt = PH_WAIT_A;
            count_nxt = '0;
            crc_nxt   = CRC_INIT;
            low_nxt   = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT_A;
      count_r <= '0;
      crc_r   <= CRC_INIT;
      low_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
      low_r   <= low_nxt;
    end
  end

  a_hunt_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_WAIT_A |-> count_r == '0 && crc_r == CRC_INIT && low_r == '0)
    else $error("hunting with stale frame state");

  a_collect_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_COLLECT |-> count_r >= POS_W'(2) && count_r <= END_POS)
    else $error("byte count out of frame range");

  a_done_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    step && (res.status == ST_CRC_OK || res.status == ST_CRC_BAD)
      |-> phase_r == PH_COLLECT && count_r == END_POS)
    else $error("frame completion reported before the last byte");

  a_done_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
    step && (res.status == ST_CRC_OK || res.status == ST_CRC_BAD)
      |=> phase_r == PH_WAIT_A)
    else $error("no return to hunting after frame end");

  a_abort_drop: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.abort |-> res.status == ST_DROP && res.position == '0)
    else $error("aborted byte not dropped");

endmodule

>>> hw/rtl/sync_header_crc16_frame_receiver.sv
// Top level of the sync-header CRC-16 frame receiver.
//
// Input channel (in_valid/in_ready) carries one received byte and an abort
// flag per transaction. Result channel (out_valid/out_ready) returns one
// transaction per input: the echoed byte, its position in the frame and a
// status (dropped, taken, frame done with CRC ok, frame done with CRC bad).
// Frames start with 'A','C' and are 39 bytes long; the last two bytes carry
// the CRC-16/CCITT-FALSE of the rest, low byte first.
//
// An accepted byte sits in the input register; when the result register is
// free or being read, the frame logic and 8-bit CRC update load the result
// register and raise out_valid. Throughput is one byte per cycle while
// out_ready stays high, set by the unrolled combinational CRC update.
//
// Reset (rst_n low, synchronous) empties both registers and puts the frame
// logic back to hunting for 'A'. When out_ready is low the result register
// holds, the input register fills behind it and in_ready drops; nothing is
// lost and frame state advances only when a byte moves into the result.
module sync_header_crc16_frame_receiver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_abort,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_frame_byte,
  output logic [5:0] out_position
);
  import shfr_pkg::*;

  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t res;
  logic    advance;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  shfr_frame_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (s1_item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r.rx_byte <= in_rx_byte;
      s1_item_r.abort   <= in_abort;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_res_r.status;
  assign out_frame_byte = out_res_r.frame_byte;
  assign out_position   = out_res_r.position;

endmodule
